/* hdl/lpmf_pkg.sv */
// shared types and constants for the length-prefixed message fifo
package lpmf_pkg;

  localparam int STORE_BYTES = 4096;
  localparam int MAX_MESSAGE = 64;
  localparam int AW = $clog2(STORE_BYTES);
  localparam int PW = AW + 1;
  localparam int LW = 7;
  localparam int CW = PW + 1;

  typedef logic [PW-1:0] ptr_t;
  typedef logic [AW-1:0] addr_t;
  typedef logic [LW-1:0] len_t;

  typedef enum logic [1:0] {
    CMD_PUT_BEGIN = 2'd0,
    CMD_PUT_BYTE  = 2'd1,
    CMD_GET       = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_TOO_LARGE = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t       cmd;
    len_t       msg_len;
    logic [7:0] data_byte;
    len_t       max_len;
  } req_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] out_byte;
    len_t       out_len;
    logic       has_byte;
    logic       last;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic put_begin;
    logic put_byte;
    logic get_empty;
    logic get_open;
    logic hdr;
    logic byte_step;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic hdr_bad;
    logic hdr_zero;
    logic final_byte;
  } sts_t;

endpackage

/* hdl/lpmf_ctrl.sv */
// controller state machine: request decode and get sequencing
module lpmf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  lpmf_pkg::cmd_t  cmd,
  input  lpmf_pkg::sts_t  sts,
  output logic            busy,
  output lpmf_pkg::ctl_t  ctl
);
  import lpmf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE      = 3'b001,
    S_GET_HDR   = 3'b010,
    S_GET_BYTES = 3'b100
  } state_t;

  state_t state, state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (cmd)
            CMD_PUT_BEGIN: ctl.put_begin = 1'b1;
            CMD_PUT_BYTE:  ctl.put_byte  = 1'b1;
            CMD_GET: begin
              if (sts.empty) begin
                ctl.get_empty = 1'b1;
              end else begin
                ctl.get_open = 1'b1;
                state_next   = S_GET_HDR;
              end
            end
            default: ;
          endcase
        end
      end
      S_GET_HDR: begin
        ctl.hdr = 1'b1;
        if (sts.hdr_bad || sts.hdr_zero) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_GET_BYTES;
        end
      end
      S_GET_BYTES: begin
        ctl.byte_step = 1'b1;
        if (sts.final_byte) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hdl/lpmf_dpath.sv */
// datapath: byte store, pointers, space check and result register
module lpmf_dpath (
  input  logic               clk,
  input  logic               rst,
  input  lpmf_pkg::req_t     req,
  input  lpmf_pkg::ctl_t     ctl,
  output lpmf_pkg::sts_t     sts,
  output logic               done,
  output lpmf_pkg::result_t  result
);
  import lpmf_pkg::*;

  logic [7:0] mem [STORE_BYTES];
  logic [7:0] rdata;

  ptr_t write_ptr, read_ptr, stage_ptr, cur;
  len_t bytes_left, cnt, max_q, len_q;
  logic put_open;

  logic [CW-1:0] need;
  logic          fits;
  ptr_t          used;
  len_t          hdr_len;
  logic          we;
  addr_t         waddr, raddr;
  logic [7:0]    wdata;
  result_t       result_next;

  assign used    = write_ptr - read_ptr;
  assign need    = CW'(used) + CW'(1) + CW'(req.msg_len);
  assign fits    = (req.msg_len <= len_t'(MAX_MESSAGE)) && (need <= CW'(STORE_BYTES));
  assign hdr_len = rdata[LW-1:0];

  assign sts.empty      = (read_ptr == write_ptr);
  assign sts.hdr_bad    = (hdr_len > max_q) || (hdr_len > len_t'(MAX_MESSAGE));
  assign sts.hdr_zero   = (hdr_len == '0);
  assign sts.final_byte = (cnt == len_t'(1));

  // single write port: header on put_begin, payload on put_byte
  always_comb begin
    we    = 1'b0;
    waddr = write_ptr[AW-1:0];
    wdata = 8'(req.msg_len);
    if (ctl.put_begin && fits) begin
      we = 1'b1;
    end else if (ctl.put_byte && put_open) begin
      we    = 1'b1;
      waddr = stage_ptr[AW-1:0];
      wdata = req.data_byte;
    end
  end

  // while a get runs the read port runs one entry ahead of the cursor
  assign raddr = (ctl.hdr || ctl.byte_step) ? addr_t'(cur + ptr_t'(1)) : read_ptr[AW-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr  <= '0;
      read_ptr   <= '0;
      stage_ptr  <= '0;
      bytes_left <= '0;
      put_open   <= 1'b0;
      done       <= 1'b0;
    end else begin
      // a header that starts a byte stream gives no result of its own
      done <= ctl.put_begin || ctl.get_empty ||
              (ctl.hdr && (sts.hdr_bad || sts.hdr_zero)) || ctl.byte_step;
      if (ctl.put_begin) begin
        put_open   <= 1'b0;
        bytes_left <= '0;
        if (fits) begin
          stage_ptr <= write_ptr + ptr_t'(1);
          if (req.msg_len == '0) begin
            write_ptr <= write_ptr + ptr_t'(1);
          end else begin
            bytes_left <= req.msg_len;
            put_open   <= 1'b1;
          end
        end
      end
      if (ctl.put_byte && put_open) begin
        stage_ptr  <= stage_ptr + ptr_t'(1);
        bytes_left <= bytes_left - len_t'(1);
        if (bytes_left == len_t'(1)) begin
          write_ptr <= stage_ptr + ptr_t'(1);
          put_open  <= 1'b0;
        end
      end
      if (ctl.hdr && sts.hdr_zero && !sts.hdr_bad) begin
        read_ptr <= cur + ptr_t'(1);
      end
      if (ctl.byte_step && sts.final_byte) begin
        read_ptr <= cur + ptr_t'(1);
      end
    end
  end

  always_comb begin
    result_next = '0;
    priority if (ctl.put_begin) begin
      result_next.status  = fits ? ST_OK : ST_NO_SPACE;
      result_next.out_len = fits ? req.msg_len : '0;
      result_next.last    = 1'b1;
    end else if (ctl.get_empty) begin
      result_next.status = ST_EMPTY;
      result_next.last   = 1'b1;
    end else if (ctl.hdr) begin
      result_next.status  = sts.hdr_bad ? ST_TOO_LARGE : ST_OK;
      result_next.out_len = sts.hdr_bad ? hdr_len : '0;
      result_next.last    = 1'b1;
    end else if (ctl.byte_step) begin
      result_next.status   = ST_OK;
      result_next.out_byte = rdata;
      result_next.out_len  = len_q;
      result_next.has_byte = 1'b1;
      result_next.last     = sts.final_byte;
    end else begin
      result_next.status = ST_OK;
    end
  end

  // get cursor, byte count and result payload
  always_ff @(posedge clk) begin
    if (ctl.get_open) begin
      cur   <= read_ptr;
      max_q <= req.max_len;
    end
    if (ctl.hdr) begin
      cur   <= cur + ptr_t'(1);
      cnt   <= hdr_len;
      len_q <= hdr_len;
    end
    if (ctl.byte_step) begin
      cur <= cur + ptr_t'(1);
      cnt <= cnt - len_t'(1);
    end

    result <= result_next;
  end

endmodule

/* hdl/length_prefixed_message_fifo.sv */
// top level of the length-prefixed message fifo
//
// A ring of STORE_BYTES byte entries holding messages as a length header
// followed by payload bytes. A request is taken on a rising edge with start
// high and busy low; req carries cmd, msg_len, data_byte and max_len.
// put_begin answers with one result (ok or no_space) in the next cycle and
// the header is written at once; put_byte gives no result, and the last
// byte publishes the message. Both keep busy low, so puts run at one
// request per cycle.
// A get that finds nothing answers empty in the next cycle without busy.
// Otherwise busy rises while the header is read from the store and then
// while each payload byte is read; each result is registered and appears in
// the cycle after its byte is read, one per clock, the final one flagged by last.
// A get holds busy until its last byte is read, so the next request waits for
// it, bounded by the one store read port; too_large and zero-length end at the header.
// Results appear on result for exactly one cycle with done high; the
// receiver cannot stall them. Reset (rst, synchronous) empties the ring and
// drops any open put; the store itself is not cleared.
module length_prefixed_message_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  lpmf_pkg::req_t     req,
  output logic               busy,
  output logic               done,
  output lpmf_pkg::result_t  result
);
  import lpmf_pkg::*;

  ctl_t ctl;
  sts_t sts;

  lpmf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (req.cmd),
    .sts   (sts),
    .busy  (busy),
    .ctl   (ctl)
  );

  lpmf_dpath u_dpath (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .ctl    (ctl),
    .sts    (sts),
    .done   (done),
    .result (result)
  );

`ifndef SYNTH
  a_ctl_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(ctl))
    else $error("more than one datapath command at once");

  a_put_begin_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req.cmd == CMD_PUT_BEGIN |=> done && result.last && !result.has_byte)
    else $error("put_begin request without a single result");

  a_put_byte_silent: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req.cmd == CMD_PUT_BYTE |=> !done)
    else $error("put_byte request produced a result");

  a_empty_get: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req.cmd == CMD_GET && sts.empty |=> done && result.status == ST_EMPTY)
    else $error("get on empty ring did not answer empty");
`endif

endmodule

/* verif/length_prefixed_message_fifo_tb.sv */
// testbench for the length-prefixed message fifo: predicted results checked against every done
`timescale 1ns / 100ps

module length_prefixed_message_fifo_tb;
  import lpmf_pkg::*;

  logic    clk = 1'b0;
  logic    rst;
  logic    start;
  req_t    req;
  logic    busy;
  logic    done;
  result_t result;

  // predicted ring contents and pointers
  logic [7:0]  ring_mem [STORE_BYTES];
  ptr_t        wr_count;
  ptr_t        rd_count;
  ptr_t        stage_count;
  len_t        bytes_pending;
  bit          put_active;

  result_t     result_q [$];
  result_t     want_res;
  int unsigned errors;
  int unsigned acted_items;
  bit          idle_on;

  length_prefixed_message_fifo dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("length_prefixed_message_fifo_tb failed");
    $finish;
  end

  function automatic int stored_bytes();
    ptr_t diff;
    diff = wr_count - rd_count;
    return int'(diff);
  endfunction

  // updates the predicted ring for one accepted request; returns 1 unless ignored
  function automatic bit predict_request(input req_t r);
    result_t     res;
    ptr_t        p;
    int unsigned n;
    res = '0;
    res.last = 1'b1;
    case (r.cmd)
      CMD_PUT_BEGIN: begin
        put_active = 1'b0;
        bytes_pending = '0;
        if (r.msg_len > MAX_MESSAGE || stored_bytes() + 1 + r.msg_len > STORE_BYTES) begin
          res.status = ST_NO_SPACE;
        end else begin
          ring_mem[wr_count[AW-1:0]] = {1'b0, r.msg_len};
          stage_count = wr_count + 1'b1;
          if (r.msg_len == 0) begin
            wr_count = stage_count;
          end else begin
            bytes_pending = r.msg_len;
            put_active = 1'b1;
          end
          res.status = ST_OK;
          res.out_len = r.msg_len;
        end
        result_q.push_back(res);
        return 1'b1;
      end
      CMD_PUT_BYTE: begin
        if (!put_active) return 1'b0;
        ring_mem[stage_count[AW-1:0]] = r.data_byte;
        stage_count = stage_count + 1'b1;
        bytes_pending = bytes_pending - 1'b1;
        // last byte makes the message visible
        if (bytes_pending == 0) begin
          wr_count = stage_count;
          put_active = 1'b0;
        end
        return 1'b1;
      end
      CMD_GET: begin
        if (rd_count == wr_count) begin
          res.status = ST_EMPTY;
          result_q.push_back(res);
          return 1'b1;
        end
        n = ring_mem[rd_count[AW-1:0]][LW-1:0];
        if (n > r.max_len || n > MAX_MESSAGE) begin
          res.status = ST_TOO_LARGE;
          res.out_len = len_t'(n);
          result_q.push_back(res);
          return 1'b1;
        end
        p = rd_count + 1'b1;
        if (n == 0) begin
          res.status = ST_OK;
          result_q.push_back(res);
          rd_count = p;
          return 1'b1;
        end
        for (int k = 0; k < n; k++) begin
          res.status = ST_OK;
          res.out_byte = ring_mem[p[AW-1:0]];
          res.out_len = len_t'(n);
          res.has_byte = 1'b1;
          res.last = (k == n - 1);
          result_q.push_back(res);
          p = p + 1'b1;
        end
        rd_count = p;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic req_t make_req(input cmd_t c, input int unsigned val);
    req_t r;
    r.cmd = c;
    r.msg_len = len_t'($urandom);
    r.data_byte = 8'($urandom);
    r.max_len = len_t'($urandom);
    case (c)
      CMD_PUT_BEGIN: r.msg_len = len_t'(val);
      CMD_PUT_BYTE:  r.data_byte = 8'(val);
      CMD_GET:       r.max_len = len_t'(val);
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (result_q.size() == 0) begin
        $display("%0t: result with none expected: status %0d byte %0d len %0d", $time,
                 result.status, result.out_byte, result.out_len);
        errors++;
      end else begin
        want_res = result_q.pop_front();
        check_field("status", want_res.status, result.status);
        check_field("out_byte", want_res.out_byte, result.out_byte);
        check_field("out_len", want_res.out_len, result.out_len);
        check_field("has_byte", want_res.has_byte, result.has_byte);
        check_field("last", want_res.last, result.last);
      end
    end
  end

  // entered and left at a falling edge; start stays high for back-to-back requests
  task automatic send_request(input req_t r);
    if (idle_on && $urandom_range(99) < 24) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start = 1'b1;
    req = r;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (predict_request(r)) acted_items++;
    @(negedge clk);
  endtask

  task automatic put_message(input int unsigned len, input int unsigned nbytes);
    send_request(make_req(CMD_PUT_BEGIN, len));
    repeat (nbytes) send_request(make_req(CMD_PUT_BYTE, $urandom_range(0, 255)));
  endtask

  task automatic test_directed();
    send_request(make_req(CMD_GET, MAX_MESSAGE));
    send_request('1);
    send_request(make_req(CMD_PUT_BEGIN, 127));
    send_request(make_req(CMD_PUT_BYTE, 8'hAA));
    send_request(make_req(CMD_PUT_BEGIN, MAX_MESSAGE + 1));
    send_request(make_req(CMD_PUT_BEGIN, 0));
    send_request(make_req(CMD_PUT_BEGIN, 2));
    send_request(make_req(CMD_PUT_BYTE, 8'h00));
    send_request(make_req(CMD_PUT_BYTE, 8'hFF));
    // abandoned put followed by a fresh one
    send_request(make_req(CMD_PUT_BEGIN, 3));
    send_request(make_req(CMD_PUT_BYTE, 8'h55));
    send_request(make_req(CMD_PUT_BEGIN, 1));
    send_request(make_req(CMD_PUT_BYTE, 8'h7F));
    send_request(make_req(CMD_GET, 0));
    send_request(make_req(CMD_GET, 1));
    send_request(make_req(CMD_GET, 127));
    send_request(make_req(CMD_GET, 1));
    send_request(make_req(CMD_GET, 0));
  endtask

  task automatic test_random_traffic();
    int unsigned base, sel, len, nbytes;
    base = acted_items;
    while (acted_items - base < 90) begin
      idle_on = (acted_items - base < 30) || (acted_items - base > 60);
      sel = $urandom_range(99);
      if (sel < 45) begin
        sel = $urandom_range(99);
        if (sel < 70) len = $urandom_range(0, 6);
        else if (sel < 90) len = $urandom_range(7, MAX_MESSAGE);
        else if (sel < 97) len = MAX_MESSAGE;
        else len = $urandom_range(MAX_MESSAGE + 1, 127);
        if (len > MAX_MESSAGE) nbytes = $urandom_range(0, 3);
        else if (len > 0 && $urandom_range(7) == 0) nbytes = $urandom_range(0, len - 1);
        else nbytes = len;
        put_message(len, nbytes);
      end else if (sel < 85) begin
        sel = $urandom_range(99);
        send_request(make_req(CMD_GET, sel < 60 ? MAX_MESSAGE :
                              sel < 85 ? $urandom_range(0, MAX_MESSAGE) :
                              $urandom_range(0, 127)));
      end else if (sel < 95) begin
        send_request(make_req(CMD_PUT_BYTE, $urandom_range(0, 255)));
      end else begin
        send_request(make_req(CMD_NONE, 0));
      end
    end
    idle_on = 1'b1;
  endtask

  task automatic wait_for_results();
    int unsigned guard;
    start = 1'b0;
    guard = 0;
    while (result_q.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (80) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    idle_on = 1'b1;
    errors = 0;
    acted_items = 0;
    wr_count = '0;
    rd_count = '0;
    stage_count = '0;
    bytes_pending = '0;
    put_active = 1'b0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random_traffic();
    wait_for_results();

    if (result_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, result_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("length_prefixed_message_fifo_tb passed");
    end else begin
      $display("length_prefixed_message_fifo_tb failed");
    end
    $finish;
  end

endmodule
